### src/clns_pkg.sv
package clns_pkg;

	typedef enum logic [2:0] {
		OP_INIT   = 3'd0,
		OP_CMD    = 3'd1,
		OP_DATA   = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_CURSOR = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] byte_value;
		logic [5:0] column;
		logic       row;
	} req_t;

	typedef struct packed {
		logic        reg_select;
		logic        enable;
		logic [3:0]  data_nibble;
		logic [15:0] duration_us;
		logic        last;
	} ivl_t;

	// one queued job: the init script or a single byte transfer
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic       long_wait;
		logic [7:0] bval;
	} job_t;

	typedef struct packed {
		logic        enable;
		logic [3:0]  nibble;
		logic [15:0] dur;
	} step_t;

	localparam int unsigned QDepth   = 2;
	localparam int unsigned QPtrW    = $clog2(QDepth);
	localparam int unsigned QCntW    = $clog2(QDepth + 1);
	localparam int unsigned StepW    = 5;

	localparam logic [StepW-1:0] LastInitStep = 5'd24;
	localparam logic [StepW-1:0] LastByteStep = 5'd3;

	localparam logic [15:0] DurStrobe  = 16'd1;
	localparam logic [15:0] DurHold    = 16'd100;
	localparam logic [15:0] DurCmd     = 16'd2100;
	localparam logic [15:0] DurClear   = 16'd4100;
	localparam logic [15:0] DurPowerUp = 16'd50000;

	localparam logic [7:0] CmdClear  = 8'h01;
	localparam logic       CursorCmd = 1'b1;

	// init script, steps 1..24: nibbles 3,3,3,2 then bytes 28, 0C, 06, 01
	function automatic step_t init_entry(logic [StepW-1:0] step);
		logic [StepW-1:0] offs;
		logic [3:0]       n;
		step_t            e;
		offs = step - 5'd1;
		n = offs[4:1];
		e.enable = step[0];
		case (n)
			4'd0: begin e.nibble = 4'h3; e.dur = 16'd5100; end
			4'd1: begin e.nibble = 4'h3; e.dur = 16'd250; end
			4'd2: begin e.nibble = 4'h3; e.dur = 16'd250; end
			4'd3: begin e.nibble = 4'h2; e.dur = DurHold; end
			4'd4: begin e.nibble = 4'h2; e.dur = DurHold; end
			4'd5: begin e.nibble = 4'h8; e.dur = DurCmd; end
			4'd6: begin e.nibble = 4'h0; e.dur = DurHold; end
			4'd7: begin e.nibble = 4'hC; e.dur = DurCmd; end
			4'd8: begin e.nibble = 4'h0; e.dur = DurHold; end
			4'd9: begin e.nibble = 4'h6; e.dur = DurCmd; end
			4'd10: begin e.nibble = 4'h0; e.dur = DurHold; end
			4'd11: begin e.nibble = 4'h1; e.dur = DurClear; end
			default: begin e.nibble = 4'h0; e.dur = DurHold; end
		endcase
		if (step[0]) begin
			e.dur = DurStrobe;
		end
		return e;
	endfunction

endpackage

### src/clns_front.sv
module clns_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  clns_pkg::req_t      req,
	output logic                head_valid,
	output clns_pkg::job_t      head,
	input  logic                pop
);

	clns_pkg::job_t                  job;
	logic                            job_ok;
	logic [6:0]                      addr;
	clns_pkg::job_t                  mem_q [clns_pkg::QDepth];
	logic [clns_pkg::QPtrW-1:0]      wr_ptr_q;
	logic [clns_pkg::QPtrW-1:0]      rd_ptr_q;
	logic [clns_pkg::QCntW-1:0]      count_q;
	logic                            push;
	logic                            do_pop;

	assign addr = {req.row, 6'b0} + {1'b0, req.column};

	always_comb begin
		job = '0;
		job_ok = 1'b1;
		case (req.operation)
			clns_pkg::OP_INIT: begin
				job.is_init = 1'b1;
			end
			clns_pkg::OP_CMD: begin
				job.bval = req.byte_value;
			end
			clns_pkg::OP_DATA: begin
				job.rs = 1'b1;
				job.bval = req.byte_value;
			end
			clns_pkg::OP_CLEAR: begin
				job.long_wait = 1'b1;
				job.bval = clns_pkg::CmdClear;
			end
			clns_pkg::OP_CURSOR: begin
				job.bval = {clns_pkg::CursorCmd, addr};
			end
			default: begin
				job_ok = 1'b0;
			end
		endcase
	end

	assign req_stall  = (count_q == clns_pkg::QCntW'(clns_pkg::QDepth));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign push       = req_valid && !req_stall && job_ok;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= clns_pkg::QCntW'(clns_pkg::QDepth))
		else $error("queue count overflow");
	a_pop_only_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> !push)
		else $error("push into full queue");
`endif

endmodule

### src/clns_back.sv
module clns_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  clns_pkg::job_t      head,
	output logic                pop,
	output logic                ivl_valid,
	input  logic                ivl_stall,
	output clns_pkg::ivl_t      ivl
);

	logic [clns_pkg::StepW-1:0] step_q;
	logic [3:0]                 held_nibble_q;
	logic                       held_select_q;
	logic                       ivl_valid_q;
	clns_pkg::ivl_t             ivl_q;
	clns_pkg::ivl_t             cur;
	clns_pkg::step_t            ient;
	logic                       last_step;
	logic                       fire;

	assign ient = clns_pkg::init_entry(step_q);
	assign last_step = head.is_init ? (step_q == clns_pkg::LastInitStep)
		: (step_q == clns_pkg::LastByteStep);

	always_comb begin
		cur.last = last_step;
		if (head.is_init) begin
			if (step_q == '0) begin
				cur.reg_select  = held_select_q;
				cur.enable      = 1'b0;
				cur.data_nibble = held_nibble_q;
				cur.duration_us = clns_pkg::DurPowerUp;
			end else begin
				cur.reg_select  = 1'b0;
				cur.enable      = ient.enable;
				cur.data_nibble = ient.nibble;
				cur.duration_us = ient.dur;
			end
		end else begin
			cur.reg_select  = head.rs;
			cur.enable      = ~step_q[0];
			cur.data_nibble = step_q[1] ? head.bval[3:0] : head.bval[7:4];
			if (!step_q[0]) begin
				cur.duration_us = clns_pkg::DurStrobe;
			end else if (!step_q[1]) begin
				cur.duration_us = clns_pkg::DurHold;
			end else begin
				cur.duration_us = head.long_wait ? clns_pkg::DurClear : clns_pkg::DurCmd;
			end
		end
	end

	assign fire      = head_valid && (!ivl_valid_q || !ivl_stall);
	assign pop       = fire && last_step;
	assign ivl_valid = ivl_valid_q;
	assign ivl       = ivl_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			ivl_q <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= '0;
			held_nibble_q <= '0;
			held_select_q <= 1'b0;
			ivl_valid_q   <= 1'b0;
		end else begin
			if (fire) begin
				ivl_valid_q <= 1'b1;
				step_q <= last_step ? '0 : step_q + 1'b1;
				if (cur.enable) begin
					held_nibble_q <= cur.data_nibble;
					held_select_q <= cur.reg_select;
				end
			end else if (!ivl_stall) begin
				ivl_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= clns_pkg::LastInitStep)
		else $error("step counter out of range");
	a_byte_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && !head.is_init) |-> (step_q <= clns_pkg::LastByteStep))
		else $error("byte job step out of range");
	a_strobe_width: assert property (@(posedge clk) disable iff (!arst_n)
		(ivl_valid_q && ivl_q.enable) |-> (ivl_q.duration_us == clns_pkg::DurStrobe))
		else $error("enable strobe not 1 us");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (step_q == '0))
		else $error("step not reset after job");
`endif

endmodule

### src/char_lcd_nibble_sequencer.sv
// Character LCD sequencer, 4-bit bus.
// Request channel (req_valid/req_stall/req): one item per request: init,
// command byte, data byte, clear or set cursor. Unused operation codes are
// accepted and dropped. A two-entry job queue sits behind the request port,
// so req_stall rises only when that queue is full.
// Interval channel (ivl_valid/ivl_stall/ivl): one item per pin interval with
// register select, enable, D4..D7 and hold time in us; last marks the final
// interval of a request.
// The first interval of a request is registered in the job queue and then in
// the output register. The interval sequencer emits one interval per cycle
// while a job is queued and ivl_stall does not hold it; a byte request is 4
// intervals and init is 25.
// Reset empties the queue and clears the output valid flag and the held pin levels (zero).
// While ivl_stall is high the pending interval holds and the sequencer
// pauses; requests keep being taken until the queue fills.
module char_lcd_nibble_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  clns_pkg::req_t      req,
	output logic                ivl_valid,
	input  logic                ivl_stall,
	output clns_pkg::ivl_t      ivl
);

	logic           head_valid;
	clns_pkg::job_t head;
	logic           pop;

	clns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	clns_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.ivl_valid  (ivl_valid),
		.ivl_stall  (ivl_stall),
		.ivl        (ivl)
	);

endmodule

### tb/sv/char_lcd_nibble_sequencer_tb.sv
`timescale 1ns / 1ps
module char_lcd_nibble_sequencer_tb;

	localparam logic [2:0] OpSpareFirst = 3'd5;
	localparam logic [2:0] OpSpareMid   = 3'd6;
	localparam logic [2:0] OpSpareLast  = 3'd7;
	localparam int unsigned CycleLimit  = 400000;
	localparam int unsigned LongHold    = 300;
	localparam int unsigned HoldAfter   = 200;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	clns_pkg::req_t req       = '0;
	logic           ivl_valid;
	logic           ivl_stall = 1'b0;
	clns_pkg::ivl_t ivl;

	clns_pkg::req_t pending_q[$];
	clns_pkg::ivl_t lcd_ivl_q[$];

	// pin levels last driven, as the block holds them
	logic [3:0] held_nib = '0;
	logic       held_rs  = 1'b0;

	clns_pkg::ivl_t iv_buf[25];
	int unsigned    iv_n;
	clns_pkg::ivl_t want;

	int unsigned send_idle_pct = 13;
	int unsigned recv_idle_pct = 66;
	int unsigned n_reqs = 0, n_inits = 0, n_ivls = 0, n_errors = 0;
	int unsigned n_cycles = 0, n_req_stalls = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	char_lcd_nibble_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.ivl_valid (ivl_valid),
		.ivl_stall (ivl_stall),
		.ivl       (ivl)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void put_ivl(logic rs, logic en, logic [3:0] nib,
		logic [15:0] dur);
		iv_buf[iv_n] = '{reg_select: rs, enable: en, data_nibble: nib, duration_us: dur,
			last: 1'b0};
		iv_n++;
	endfunction

	function automatic void put_nibble(logic rs, logic [3:0] nib, logic [15:0] extra);
		held_nib = nib;
		held_rs = rs;
		put_ivl(rs, 1'b1, nib, 16'd1);
		put_ivl(rs, 1'b0, nib, 16'd100 + extra);
	endfunction

	function automatic void put_byte(logic rs, logic [7:0] b, logic [15:0] extra);
		put_nibble(rs, b[7:4], 16'd0);
		put_nibble(rs, b[3:0], 16'd2000 + extra);
	endfunction

	function automatic void predict_intervals(clns_pkg::req_t r);
		logic [6:0] addr;
		iv_n = 0;
		case (r.operation)
			clns_pkg::OP_INIT: begin
				n_inits++;
				put_ivl(held_rs, 1'b0, held_nib, 16'd50000);
				put_nibble(1'b0, 4'h3, 16'd5000);
				put_nibble(1'b0, 4'h3, 16'd150);
				put_nibble(1'b0, 4'h3, 16'd150);
				put_nibble(1'b0, 4'h2, 16'd0);
				put_byte(1'b0, 8'h28, 16'd0);
				put_byte(1'b0, 8'h0C, 16'd0);
				put_byte(1'b0, 8'h06, 16'd0);
				put_byte(1'b0, 8'h01, 16'd2000);
			end
			clns_pkg::OP_CMD: put_byte(1'b0, r.byte_value, 16'd0);
			clns_pkg::OP_DATA: put_byte(1'b1, r.byte_value, 16'd0);
			clns_pkg::OP_CLEAR: put_byte(1'b0, 8'h01, 16'd2000);
			clns_pkg::OP_CURSOR: begin
				addr = (r.row ? 7'h40 : 7'h00) + {1'b0, r.column};
				put_byte(1'b0, {1'b1, addr}, 16'd0);
			end
			default: ;
		endcase
		if (iv_n > 0) begin
			iv_buf[iv_n - 1].last = 1'b1;
		end
		for (int i = 0; i < iv_n; i++) begin
			lcd_ivl_q.push_back(iv_buf[i]);
		end
	endfunction

	function automatic clns_pkg::req_t make_req(logic [2:0] op, logic [7:0] b,
		logic [5:0] col, logic row);
		clns_pkg::req_t r;
		r.operation = op;
		r.byte_value = b;
		r.column = col;
		r.row = row;
		return r;
	endfunction

	function automatic clns_pkg::req_t rand_req();
		clns_pkg::req_t r;
		int unsigned    pick;
		r.byte_value = 8'($urandom);
		r.column = 6'($urandom);
		r.row = 1'($urandom);
		pick = $urandom_range(99);
		if (pick < 6) r.operation = clns_pkg::OP_INIT;
		else if (pick < 36) r.operation = clns_pkg::OP_CMD;
		else if (pick < 66) r.operation = clns_pkg::OP_DATA;
		else if (pick < 74) r.operation = clns_pkg::OP_CLEAR;
		else if (pick < 94) r.operation = clns_pkg::OP_CURSOR;
		else r.operation = 3'($urandom_range(OpSpareLast, OpSpareFirst));
		return r;
	endfunction

	task automatic queue_random(int unsigned count);
		int unsigned    got;
		clns_pkg::req_t r;
		got = 0;
		while (got < count) begin
			r = rand_req();
			pending_q.push_back(r);
			if (r.operation <= clns_pkg::OP_CURSOR) got++;
		end
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || req_valid || lcd_ivl_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic check_field(string fname, logic [15:0] want_v, logic [15:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want_v, got_v);
			n_errors++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_intervals(req);
				n_reqs++;
			end
			if (req_valid && req_stall) n_req_stalls++;
			if (!req_valid || !req_stall) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= pending_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// interval monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ivl_stall <= 1'b0;
		end else begin
			if (ivl_valid && !ivl_stall) begin
				n_ivls++;
				if (lcd_ivl_q.size() == 0) begin
					$display("%0t: unexpected interval: expected none, actual %h", $time, ivl);
					n_errors++;
				end else begin
					want = lcd_ivl_q.pop_front();
					check_field("reg_select", 16'(want.reg_select), 16'(ivl.reg_select));
					check_field("enable", 16'(want.enable), 16'(ivl.enable));
					check_field("data_nibble", 16'(want.data_nibble), 16'(ivl.data_nibble));
					check_field("duration_us", want.duration_us, ivl.duration_us);
					check_field("last", 16'(want.last), 16'(ivl.last));
				end
			end
			if (!hold_done && n_ivls >= HoldAfter) begin
				hold_done = 1'b1;
				hold_left = LongHold;
			end
			if (hold_left > 0) begin
				hold_left--;
				ivl_stall <= 1'b1;
			end else begin
				ivl_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= CycleLimit) begin
			$display("%0t: timeout with %0d intervals outstanding", $time, lcd_ivl_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: init from reset levels, byte extremes, held levels into init,
		// ignored fields, cursor corners, spare codes
		pending_q.push_back(make_req(clns_pkg::OP_INIT, 8'h00, 6'd0, 1'b0));
		pending_q.push_back(make_req(clns_pkg::OP_CMD, 8'h00, 6'd0, 1'b0));
		pending_q.push_back(make_req(clns_pkg::OP_CMD, 8'hFF, 6'd63, 1'b1));
		pending_q.push_back(make_req(clns_pkg::OP_DATA, 8'h00, 6'd0, 1'b0));
		pending_q.push_back(make_req(clns_pkg::OP_DATA, 8'hFF, 6'd63, 1'b1));
		pending_q.push_back(make_req(clns_pkg::OP_DATA, 8'hA5, 6'd0, 1'b0));
		pending_q.push_back(make_req(clns_pkg::OP_INIT, 8'hFF, 6'd63, 1'b1));
		pending_q.push_back(make_req(clns_pkg::OP_CLEAR, 8'hFF, 6'd63, 1'b1));
		pending_q.push_back(make_req(clns_pkg::OP_CURSOR, 8'h00, 6'd0, 1'b0));
		pending_q.push_back(make_req(clns_pkg::OP_CURSOR, 8'hFF, 6'd63, 1'b1));
		pending_q.push_back(make_req(clns_pkg::OP_CURSOR, 8'h00, 6'd63, 1'b0));
		pending_q.push_back(make_req(clns_pkg::OP_CURSOR, 8'h00, 6'd0, 1'b1));
		pending_q.push_back(make_req(OpSpareFirst, 8'hFF, 6'd63, 1'b1));
		pending_q.push_back(make_req(OpSpareMid, 8'h00, 6'd0, 1'b0));
		pending_q.push_back(make_req(OpSpareLast, 8'h5A, 6'd21, 1'b1));
		pending_q.push_back(make_req(clns_pkg::OP_CMD, 8'h5A, 6'd0, 1'b0));
		pending_q.push_back(make_req(clns_pkg::OP_DATA, 8'hC3, 6'd0, 1'b0));
		pending_q.push_back(make_req(clns_pkg::OP_INIT, 8'h00, 6'd0, 1'b0));
		pending_q.push_back(make_req(clns_pkg::OP_CLEAR, 8'h00, 6'd0, 1'b0));
		pending_q.push_back(make_req(clns_pkg::OP_CURSOR, 8'h3C, 6'd42, 1'b1));
		queue_random(50);
		drain();

		send_idle_pct = 66;
		recv_idle_pct = 13;
		queue_random(45);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(45);
		drain();

		repeat (30) @(posedge clk);
		if (lcd_ivl_q.size() != 0) begin
			$display("%0t: %0d intervals never arrived", $time, lcd_ivl_q.size());
			n_errors++;
		end
		$display("Covered %0d requests (%0d init) and %0d intervals over three idle mixes,",
			n_reqs, n_inits, n_ivls);
		$display("with a %0d-cycle output hold; request port stalled %0d cycles.",
			LongHold, n_req_stalls);
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
